// ===== rtl/sliding_window_min_2d_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_MIN_2D_DEFINES_SVH
`define SLIDING_WINDOW_MIN_2D_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SWM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SWM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
package swm_pkg;

    localparam int PIXEL_BITS   = 32;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_WIN_ROWS = 16;
    localparam int MAX_WIN_COLS = 16;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ROW_SLOT_W = $clog2(MAX_WIN_ROWS);
    localparam int COL_SLOT_W = $clog2(MAX_WIN_COLS);
    localparam int GRID_CFG_W = 11;
    localparam int WIN_CFG_W  = 5;
    localparam int REG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_WINDOW_ROWS = 2'd2,
        REG_WINDOW_COLS = 2'd3
    } t_reg_idx;

    // One pixel request as it travels down the cell chain
    typedef struct packed {
        logic                  valid;
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] cm;      // running column minimum
        logic [PIXEL_BITS-1:0] hm;      // running window minimum
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [ROW_SLOT_W-1:0] rslot;
        logic [COL_SLOT_W-1:0] cslot;
        logic [WIN_CFG_W-1:0]  wr;
        logic [WIN_CFG_W-1:0]  wc;
        logic                  vld_v;   // window rows complete
        logic                  vld_h;   // full window complete
        logic                  last;
    } t_rec;

    // Treat zero as one and saturate at hi
    function automatic logic [GRID_CFG_W-1:0] clamp_u(
        input logic [GRID_CFG_W-1:0] v,
        input logic [GRID_CFG_W-1:0] hi
    );
        logic [GRID_CFG_W-1:0] res;
        if (v == '0) begin
            res = GRID_CFG_W'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/sliding_window_min_2d.sv =====
// Pipeline: an accepted pixel's result passes through 16 row cells, 16 column cells and the
// output register; the first row cell loads on acceptance.
// Throughput: one pixel per cycle; o_pixel_ready drops only while a result sits in the last
// column cell and the output register holds an untaken result.
// Reset (synchronous, active low) clears position, pipeline valids and column minima and
// loads the registers with 1024, 1024, 1, 1; line memories are not cleared.
`timescale 1ns / 1ps
module sliding_window_min_2d
    import swm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel_value,
    // results
    output logic                  o_result_valid,
    input  logic                  i_result_ready,
    output logic [31:0]           o_window_min,
    output logic [9:0]            o_out_row,
    output logic [9:0]            o_out_col,
    output logic                  o_frame_last,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [GRID_CFG_W-1:0] r_grid_width;
    logic [GRID_CFG_W-1:0] r_grid_height;
    logic [WIN_CFG_W-1:0]  r_window_rows;
    logic [WIN_CFG_W-1:0]  r_window_cols;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [GRID_CFG_W-1:0] w_w;
    logic [GRID_CFG_W-1:0] w_h;
    logic [WIN_CFG_W-1:0]  w_wr;
    logic [WIN_CFG_W-1:0]  w_wc;
    logic [GRID_CFG_W-1:0] w_row_p1;
    logic [GRID_CFG_W-1:0] w_col_p1;
    logic                  w_accept;
    logic                  w_adv;
    logic                  w_tail_res;
    logic                  w_cfg_wr;
    t_reg_idx              w_reg;
    t_rec                  w_line [MAX_WIN_ROWS+1];
    t_rec                  w_col  [MAX_WIN_COLS+1];
    logic                  r_out_valid;
    logic [31:0]           r_out_min;
    logic [9:0]            r_out_row;
    logic [9:0]            r_out_col;
    logic                  r_out_last;

    // Configuration port
    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_CFG_W'(MAX_WIDTH);
            r_grid_height <= GRID_CFG_W'(MAX_HEIGHT);
            r_window_rows <= WIN_CFG_W'(1);
            r_window_cols <= WIN_CFG_W'(1);
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[GRID_CFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[GRID_CFG_W-1:0];
                REG_WINDOW_ROWS: r_window_rows <= pwdata[WIN_CFG_W-1:0];
                REG_WINDOW_COLS: r_window_cols <= pwdata[WIN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(r_grid_height);
            REG_WINDOW_ROWS: prdata = APB_DATA_W'(r_window_rows);
            REG_WINDOW_COLS: prdata = APB_DATA_W'(r_window_cols);
            default:         prdata = '0;
        endcase
    end

    // Effective sizes
    assign w_w  = clamp_u(r_grid_width, GRID_CFG_W'(MAX_WIDTH));
    assign w_h  = clamp_u(r_grid_height, GRID_CFG_W'(MAX_HEIGHT));
    assign w_wr = WIN_CFG_W'(clamp_u(GRID_CFG_W'(r_window_rows), GRID_CFG_W'(MAX_WIN_ROWS)));
    assign w_wc = WIN_CFG_W'(clamp_u(GRID_CFG_W'(r_window_cols), GRID_CFG_W'(MAX_WIN_COLS)));

    // Stall only when a result must enter a full, blocked output register
    assign w_tail_res    = w_col[MAX_WIN_COLS].valid && w_col[MAX_WIN_COLS].vld_h;
    assign w_adv         = !(w_tail_res && r_out_valid && !i_result_ready);
    assign o_pixel_ready = w_adv;
    assign w_accept      = i_pixel_valid && w_adv;

    assign w_row_p1 = GRID_CFG_W'(r_row) + GRID_CFG_W'(1);
    assign w_col_p1 = GRID_CFG_W'(r_col) + GRID_CFG_W'(1);

    // Build the request at the head of the chain
    always_comb begin
        w_line[0].valid = w_accept;
        w_line[0].px    = i_pixel_value;
        w_line[0].cm    = i_pixel_value;
        w_line[0].hm    = i_pixel_value;
        w_line[0].row   = r_row;
        w_line[0].col   = r_col;
        w_line[0].rslot = r_row[ROW_SLOT_W-1:0];
        w_line[0].cslot = r_col[COL_SLOT_W-1:0];
        w_line[0].wr    = w_wr;
        w_line[0].wc    = w_wc;
        w_line[0].vld_v = w_row_p1 >= GRID_CFG_W'(w_wr);
        w_line[0].vld_h = (w_row_p1 >= GRID_CFG_W'(w_wr)) && (w_col_p1 >= GRID_CFG_W'(w_wc));
        w_line[0].last  = (GRID_CFG_W'(r_row) == w_h - GRID_CFG_W'(1))
                          && (GRID_CFG_W'(r_col) == w_w - GRID_CFG_W'(1));
    end

    // Advance the raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (w_col_p1 >= w_w) begin
                r_col <= '0;
                r_row <= (w_row_p1 >= w_h) ? '0 : w_row_p1[ROW_W-1:0];
            end else begin
                r_col <= w_col_p1[COL_W-1:0];
            end
        end
    end

    // Row cells: minimum down the column
    for (genvar g = 0; g < MAX_WIN_ROWS; g++) begin : g_line
        swm_line_cell u_line (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_slot  (ROW_SLOT_W'(g)),
            .i_rec   (w_line[g]),
            .o_rec   (w_line[g+1])
        );
    end

    // Start the window minimum from the column minimum
    always_comb begin
        w_col[0]    = w_line[MAX_WIN_ROWS];
        w_col[0].hm = w_line[MAX_WIN_ROWS].cm;
    end

    // Column cells: minimum across the window
    for (genvar g = 0; g < MAX_WIN_COLS; g++) begin : g_col
        swm_col_cell u_col (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_slot  (COL_SLOT_W'(g)),
            .i_rec   (w_col[g]),
            .o_rec   (w_col[g+1])
        );
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_tail_res) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_tail_res) begin
            r_out_min  <= w_col[MAX_WIN_COLS].hm[31:0];
            r_out_row  <= 10'(w_col[MAX_WIN_COLS].row);
            r_out_col  <= 10'(w_col[MAX_WIN_COLS].col);
            r_out_last <= w_col[MAX_WIN_COLS].last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_window_min   = r_out_min;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_frame_last   = r_out_last;

endmodule

// ===== rtl/swm_line_cell.sv =====
`timescale 1ns / 1ps
module swm_line_cell
    import swm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [ROW_SLOT_W-1:0] i_slot,
    input  t_rec                  i_rec,
    output t_rec                  o_rec
);

    logic [PIXEL_BITS-1:0] r_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd;
    t_rec                  r_rec;
    logic                  r_vld;
    logic                  w_wen;
    logic [ROW_SLOT_W-1:0] w_dist;
    logic                  w_inc;

    // This cell owns one row slot of the line store
    assign w_wen = i_rec.valid && (i_rec.rslot == i_slot);

    // Write the pixel into its own slot, read the same column of this slot
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_wen) begin
                r_mem[i_rec.col] <= i_rec.px;
            end
            r_rd <= r_mem[i_rec.col];
        end
    end

    // Advance the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec <= i_rec;
        end
    end

    // Fold this slot in when it is one of the window's earlier rows
    assign w_dist = r_rec.rslot - i_slot;
    assign w_inc  = r_vld && r_rec.vld_v && (r_rec.rslot != i_slot)
                    && ({1'b0, w_dist} < r_rec.wr);

    always_comb begin
        o_rec       = r_rec;
        o_rec.valid = r_vld;
        if (w_inc && (r_rd < r_rec.cm)) begin
            o_rec.cm = r_rd;
        end
    end

endmodule

// ===== rtl/swm_col_cell.sv =====
`timescale 1ns / 1ps
module swm_col_cell
    import swm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [COL_SLOT_W-1:0] i_slot,
    input  t_rec                  i_rec,
    output t_rec                  o_rec
);

    logic [PIXEL_BITS-1:0] r_cm;
    t_rec                  r_rec;
    logic                  r_vld;
    logic                  w_wen;
    logic [COL_SLOT_W-1:0] w_dist;
    logic                  w_inc;
    t_rec                  n_rec;

    assign w_wen  = i_rec.valid && i_rec.vld_v && (i_rec.cslot == i_slot);
    assign w_dist = i_rec.cslot - i_slot;
    assign w_inc  = i_rec.valid && i_rec.vld_h && (i_rec.cslot != i_slot)
                    && ({1'b0, w_dist} < i_rec.wc);

    // Fold this column minimum into the window minimum
    always_comb begin
        n_rec = i_rec;
        if (w_inc && (r_cm < i_rec.hm)) begin
            n_rec.hm = r_cm;
        end
    end

    // Hold the column minimum of this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm  <= '0;
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_rec.valid;
            if (w_wen) begin
                r_cm <= i_rec.cm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec <= n_rec;
        end
    end

    always_comb begin
        o_rec       = r_rec;
        o_rec.valid = r_vld;
    end

endmodule

// ===== rtl/swm_checker.sv =====
`timescale 1ns / 1ps
`include "sliding_window_min_2d_defines.svh"
module swm_checker
    import swm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_pixel_valid,
    input logic                  o_pixel_ready,
    input logic [PIXEL_BITS-1:0] i_pixel_value,
    input logic                  o_result_valid,
    input logic                  i_result_ready,
    input logic [31:0]           o_window_min,
    input logic [9:0]            o_out_row,
    input logic [9:0]            o_out_col,
    input logic                  o_frame_last,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [REG_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    logic [52:0]           w_result;
    logic                  w_px_wait;
    logic                  w_res_wait;
    logic                  w_width_rd;
    logic                  w_width_wr;
    logic [APB_DATA_W-1:0] w_width_data;

    assign w_result     = {o_window_min, o_out_row, o_out_col, o_frame_last};
    assign w_px_wait    = i_pixel_valid && !o_pixel_ready;
    assign w_res_wait   = o_result_valid && !i_result_ready;
    assign w_width_rd   = psel && !pwrite && (paddr[3:2] == REG_GRID_WIDTH);
    assign w_width_wr   = i_rst_n && psel && penable && pwrite && pready
                          && (paddr[3:2] == REG_GRID_WIDTH);
    assign w_width_data = {{(APB_DATA_W-GRID_CFG_W){1'b0}}, pwdata[GRID_CFG_W-1:0]};

    // A waiting pixel request keeps its value until accepted
    `SWM_ASSERT_NXT(a_pixel_hold, w_px_wait, i_pixel_valid && $stable(i_pixel_value))

    // A waiting result stays until taken
    `SWM_ASSERT_NXT(a_result_hold, w_res_wait, o_result_valid)

    // A waiting result keeps its fields
    `SWM_ASSERT_NXT(a_result_stable, w_res_wait, $stable(w_result))

    // No result can leave the chain right after reset
    `SWM_ASSERT_IMP(a_no_early_result, $rose(i_rst_n), !o_result_valid)

    // A width write reads back masked on the next cycle
    `SWM_ASSERT_IMP(a_width_readback, w_width_rd && $past(w_width_wr), prdata == $past(w_width_data))

endmodule

bind sliding_window_min_2d swm_checker u_swm_checker (.*);

// ===== bench/tb_sliding_window_min_2d.sv =====
`timescale 1ns / 1ps
module tb_sliding_window_min_2d
    import swm_pkg::*;
;

    localparam int unsigned RANDOM_ITEMS = 750;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    // One window result as seen on the output port
    typedef struct packed {
        logic [31:0] wmin;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        last;
    } t_win_result;

    // Window minimum predictor and the queue of results it has promised
    class t_window_min_sb;
        localparam int MAX_REPORTS = 40;

        bit [PIXEL_BITS-1:0] line_buf [MAX_WIN_ROWS][MAX_WIDTH];
        bit [PIXEL_BITS-1:0] col_min [MAX_WIN_COLS];
        int unsigned row_pos, col_pos;
        int unsigned cfg_width, cfg_height, cfg_wrows, cfg_wcols;
        t_win_result expected_q[$];
        int errors, n_pixels, n_results, n_frame_ends;

        function new();
            row_pos    = 0;
            col_pos    = 0;
            cfg_width  = 1024;
            cfg_height = 1024;
            cfg_wrows  = 1;
            cfg_wcols  = 1;
            errors     = 0;
            n_pixels   = 0;
            n_results  = 0;
            n_frame_ends = 0;
        endfunction

        // Zero acts as one, large values saturate
        function int unsigned limit_to(int unsigned v, int unsigned hi);
            if (v == 0) begin
                return 1;
            end
            return (v > hi) ? hi : v;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_GRID_WIDTH:  cfg_width  = val[GRID_CFG_W-1:0];
                REG_GRID_HEIGHT: cfg_height = val[GRID_CFG_W-1:0];
                REG_WINDOW_ROWS: cfg_wrows  = val[WIN_CFG_W-1:0];
                REG_WINDOW_COLS: cfg_wcols  = val[WIN_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_pixels();
            return limit_to(cfg_width, MAX_WIDTH) * limit_to(cfg_height, MAX_HEIGHT);
        endfunction

        // Pixels left until the current row wraps under the present width
        function int unsigned pixels_to_row_end();
            int unsigned w, c;
            w = limit_to(cfg_width, MAX_WIDTH);
            c = col_pos % MAX_WIDTH;
            return (c + 1 >= w) ? 1 : w - c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Store the pixel, update column minima, queue a window result if one completes
        function void note_pixel(logic [PIXEL_BITS-1:0] px);
            int unsigned w, h, wr, wc, r, c, rs, cs, k;
            bit [PIXEL_BITS-1:0] cm, m, v;
            t_win_result res;
            w  = limit_to(cfg_width, MAX_WIDTH);
            h  = limit_to(cfg_height, MAX_HEIGHT);
            wr = limit_to(cfg_wrows, MAX_WIN_ROWS);
            wc = limit_to(cfg_wcols, MAX_WIN_COLS);
            r  = row_pos;
            c  = col_pos % MAX_WIDTH;
            rs = r % MAX_WIN_ROWS;
            cs = c % MAX_WIN_COLS;
            n_pixels++;
            line_buf[rs][c] = px;
            if (r + 1 >= wr) begin
                cm = px;
                for (k = 1; k < wr; k++) begin
                    v = line_buf[(rs + MAX_WIN_ROWS - k) % MAX_WIN_ROWS][c];
                    if (v < cm) begin
                        cm = v;
                    end
                end
                col_min[cs] = cm;
                if (c + 1 >= wc) begin
                    m = cm;
                    for (k = 1; k < wc; k++) begin
                        v = col_min[(cs + MAX_WIN_COLS - k) % MAX_WIN_COLS];
                        if (v < m) begin
                            m = v;
                        end
                    end
                    res.wmin = m[31:0];
                    res.row  = 10'(r);
                    res.col  = 10'(c);
                    res.last = (r == h - 1) && (c == w - 1);
                    expected_q.insert(expected_q.size(), res);
                end
            end
            // advance the raster position
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 'h3FF);
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
            end
        endfunction

        // Compare one accepted result with the oldest promised one
        function void check_result(logic [31:0] wmin, logic [9:0] row, logic [9:0] col,
                                   logic last);
            t_win_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result with none expected: min %0h row %0d col %0d last %0b",
                             $time, wmin, row, col, last);
                end
                return;
            end
            exp_r = expected_q[0];
            expected_q.delete(0);
            n_results++;
            if (exp_r.last) begin
                n_frame_ends++;
            end
            if (exp_r.wmin !== wmin) begin
                report("window_min", exp_r.wmin, wmin);
            end
            if (exp_r.row !== row) begin
                report("out_row", 32'(exp_r.row), 32'(row));
            end
            if (exp_r.col !== col) begin
                report("out_col", 32'(exp_r.col), 32'(col));
            end
            if (exp_r.last !== last) begin
                report("frame_last", 32'(exp_r.last), 32'(last));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_pixel_valid;
    logic                  o_pixel_ready;
    logic [PIXEL_BITS-1:0] i_pixel_value;
    logic                  o_result_valid;
    logic                  i_result_ready;
    logic [31:0]           o_window_min;
    logic [9:0]            o_out_row;
    logic [9:0]            o_out_col;
    logic                  o_frame_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_window_min_sb sb;
    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned phase_count;
    int unsigned stream_items;
    int unsigned cycle_count;

    sliding_window_min_2d dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Receiver: stall at random according to the current traffic mix
    always @(posedge i_clk) begin
        if (stall_pct == 0) begin
            i_result_ready <= 1'b1;
        end else begin
            i_result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Note accepted pixels, check accepted results, watch the cycle budget
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (i_pixel_valid && o_pixel_ready) begin
                sb.note_pixel(i_pixel_value);
            end
            if (o_result_valid && i_result_ready) begin
                sb.check_result(o_window_min, o_out_row, o_out_col, o_frame_last);
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: cycle limit reached with %0d results outstanding",
                         $time, sb.pending());
                $display("sliding_window_min_2d: mismatch");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_height();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return 32'($urandom_range(0, 15));
            4: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Window size for a grid extent: mostly one that fits, sometimes zero or oversized
    function automatic int unsigned pick_window(input int unsigned extent);
        int unsigned hi;
        hi = (extent == 0) ? 1 : ((extent > MAX_WIN_ROWS) ? MAX_WIN_ROWS : extent);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 31);
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    // Offer one pixel, with random gaps before it, and hold it until accepted
    task automatic send_pixel(input logic [31:0] px);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_pixel_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel_value <= px;
        @(posedge i_clk);
        while (!o_pixel_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) begin
            send_pixel(pick_height());
            stream_items++;
        end
    endtask

    // Drop valid, wait for every promised result, then let the pipeline empty
    task automatic drain_results();
        i_pixel_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle then access cycle; psel stays high into the next setup
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.set_reg(idx, val);
    endtask

    // Load all four registers and move to the next traffic mix
    task automatic program_grid(input int unsigned width, input int unsigned height,
                                input int unsigned wrows, input int unsigned wcols);
        write_reg(REG_GRID_WIDTH, width);
        write_reg(REG_GRID_HEIGHT, height);
        write_reg(REG_WINDOW_ROWS, wrows);
        write_reg(REG_WINDOW_COLS, wcols);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phase_count++;
        case (phase_count % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 54; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 54; end
            default: begin gap_pct = 34; stall_pct = 34; end
        endcase
    endtask

    initial begin
        int unsigned w, h;
        sb = new();
        gap_pct      = 0;
        stall_pct    = 0;
        phase_count  = 0;
        stream_items = 0;
        cycle_count  = 0;
        i_rst_n       <= 1'b0;
        i_pixel_valid <= 1'b0;
        i_pixel_value <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: wide frame, one-pixel window, each pixel is its own minimum
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hAAAA_AAAA);
        send_pixel(32'h5555_5555);
        drain_results();

        // Shrink the grid mid-row: the next pixel closes the row and the position wraps back to the frame start
        program_grid(1, 1, 1, 1);
        send_pixel(32'h8000_0001);
        drain_results();

        // Zero in every register acts as one
        program_grid(0, 0, 0, 0);
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'h0000_0001);
        drain_results();

        // Small grid with a 2x3 window, minima placed on window edges
        program_grid(4, 3, 2, 3);
        send_pixel(32'd50);
        send_pixel(32'd40);
        send_pixel(32'd30);
        send_pixel(32'd20);
        send_pixel(32'd10);
        send_pixel(32'd60);
        send_pixel(32'd70);
        send_pixel(32'd80);
        send_pixel(32'd90);
        send_pixel(32'd5);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'd0);
        drain_results();

        // Window taller than the grid never completes
        program_grid(2, 2, 3, 2);
        send_random(4);
        drain_results();

        // Random grids: mostly whole frames, some cut short and closed under a new width
        stream_items = 0;
        while (stream_items < RANDOM_ITEMS) begin
            w = $urandom_range(0, 10);
            h = $urandom_range(0, 10);
            program_grid(w, h, pick_window(h), pick_window(w));
            if ($urandom_range(0, 9) == 0 && sb.frame_pixels() > 1) begin
                send_random($urandom_range(1, sb.frame_pixels() - 1));
                drain_results();
                program_grid($urandom_range(1, 10), 1, 1, $urandom_range(0, 31));
                send_random(sb.pixels_to_row_end());
            end else begin
                send_random(sb.frame_pixels() * $urandom_range(1, 2));
            end
            drain_results();
        end

        // Oversized window registers on a grid just larger than the window
        program_grid(18, 17, 31, 31);
        send_random(sb.frame_pixels());
        drain_results();

        $display("Covered %0d pixels under %0d register settings with mixed gaps and stalls;",
                 sb.n_pixels, phase_count + 1);
        $display("%0d window minima checked, %0d of them frame ends.",
                 sb.n_results, sb.n_frame_ends);
        if (sb.errors == 0) begin
            $display("sliding_window_min_2d: match");
        end else begin
            $display("sliding_window_min_2d: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_line_cell.sv
rtl/swm_col_cell.sv
rtl/sliding_window_min_2d.sv
rtl/swm_checker.sv
bench/tb_sliding_window_min_2d.sv
